>>> rtl/core/mmws_pkg.sv
package mmws_pkg;

	localparam int unsigned LIMB_W = 32;
	localparam int unsigned CNT_W  = 6;

	typedef struct packed {
		logic [LIMB_W-1:0] x_limb;
		logic [LIMB_W-1:0] y_limb;
		logic [LIMB_W-1:0] modulus_limb;
	} in_item_t;

	typedef struct packed {
		logic [LIMB_W-1:0] result_limb;
		logic              last_out;
	} out_item_t;

	typedef enum logic [0:0] {
		REG_LIMB_COUNT = 1'b0,
		REG_MOD_INV    = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CLEAR,
		ST_U0,
		ST_U1,
		ST_MAC,
		ST_TOP,
		ST_CMP,
		ST_SUB,
		ST_EMIT
	} state_t;

endpackage

>>> rtl/core/montgomery_modmul_word_serial.sv
// Word-serial Montgomery multiplier, limb base 2^32.
// Input channel (in_valid/in_stall/in_data): each transfer carries one limb of
// x, y and the modulus, least significant first. The transfer that completes
// limb_count limbs starts the operation; in_stall is high from then until the
// last result limb has been taken.
// Output channel (out_valid/out_stall/out_data): n result limbs of
// x*y*R^-1 mod m, least significant first, last_out on the top limb.
// Configuration (cfg_we/cfg_index/cfg_data): index 0 limb_count, 1 the
// negated inverse of m modulo 2^32. Write only while idle.
// Sequence: an n+1-limb accumulator clear, then n rounds on the
// single 32x32 multiplier (four sub-steps per limb: address, x*y, u*m, write),
// then a compare from the top limb down, a subtract when r >= m and the
// emission of the result limbs. One operation at a time.
// Reset: limb_count returns to 32, the inverse to 0, the load count to zero.
// Operand stores are RAMs without reset; the accumulator is cleared by a
// short sweep at the start of every operation.
// A stalled result limb simply holds in the output register.
module montgomery_modmul_word_serial
	import mmws_pkg::*;
#(
	parameter int unsigned MAX_LIMBS = 32,
	parameter int unsigned LIMB_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [LIMB_BITS-1:0] cfg_data
);
	localparam int unsigned AW  = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
	localparam int unsigned AAW = $clog2(MAX_LIMBS + 1);
	localparam int unsigned IW  = $clog2(MAX_LIMBS + 2);

	state_t state_q, state_d;

	logic [CNT_W-1:0]     limb_count_q;
	logic [LIMB_BITS-1:0] minv_q;
	logic [CNT_W-1:0]     load_q;
	logic [IW-1:0]        n_q;       // effective limb count
	logic [IW-1:0]        i_q, j_q;  // round and limb indices
	logic [1:0]           ph_q;      // sub-step inside a limb
	logic [LIMB_BITS-1:0] xi_q, ui_q, a0_q;
	logic [LIMB_BITS-1:0] c1_q, c2_q, t1lo_q;
	logic [2*LIMB_BITS-1:0] prod_s1;
	logic                 ge_q, borrow_q, cmp_done_q;

	// effective limb count from register
	logic [IW-1:0] n_eff;
	always_comb begin
		if (limb_count_q == '0) begin
			n_eff = IW'(1);
		end else if (IW'(limb_count_q) > IW'(MAX_LIMBS) || 32'(limb_count_q) > MAX_LIMBS) begin
			n_eff = IW'(MAX_LIMBS);
		end else begin
			n_eff = IW'(limb_count_q);
		end
	end

	logic in_xfer, out_xfer;
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	// operand RAMs: x, y, m
	logic            op_we;
	logic [AW-1:0]   op_waddr, op_raddr;
	logic [LIMB_BITS-1:0] x_rd, y_rd, m_rd;
	assign op_we    = in_xfer && (32'(load_q) < MAX_LIMBS);
	assign op_waddr = load_q[AW-1:0];

	mmws_ram #(.WIDTH(LIMB_BITS), .DEPTH(MAX_LIMBS)) u_x (
		.clk, .we(op_we), .waddr(op_waddr), .wdata(in_data.x_limb),
		.raddr(op_raddr), .rdata(x_rd));
	mmws_ram #(.WIDTH(LIMB_BITS), .DEPTH(MAX_LIMBS)) u_y (
		.clk, .we(op_we), .waddr(op_waddr), .wdata(in_data.y_limb),
		.raddr(op_raddr), .rdata(y_rd));
	mmws_ram #(.WIDTH(LIMB_BITS), .DEPTH(MAX_LIMBS)) u_m (
		.clk, .we(op_we), .waddr(op_waddr), .wdata(in_data.modulus_limb),
		.raddr(op_raddr), .rdata(m_rd));

	// accumulator RAM, n+1 limbs
	logic                 acc_we;
	logic [AAW-1:0]       acc_waddr, acc_raddr;
	logic [LIMB_BITS-1:0] acc_wdata, acc_rd;
	mmws_ram #(.WIDTH(LIMB_BITS), .DEPTH(MAX_LIMBS + 1)) u_acc (
		.clk, .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
		.raddr(acc_raddr), .rdata(acc_rd));

	// shared multiplier operands
	logic [LIMB_BITS-1:0] mul_a, mul_b;

	// sums
	logic [2*LIMB_BITS-1:0] t1_sum, t2_sum;
	logic [LIMB_BITS+1:0]   top_sum;
	logic [LIMB_BITS:0]     sub_d;
	assign t1_sum  = prod_s1 + (2*LIMB_BITS)'(acc_rd) + (2*LIMB_BITS)'(c1_q);
	assign t2_sum  = prod_s1 + (2*LIMB_BITS)'(t1lo_q) + (2*LIMB_BITS)'(c2_q);
	assign top_sum = (LIMB_BITS+2)'(acc_rd) + (LIMB_BITS+2)'(c1_q) + (LIMB_BITS+2)'(c2_q);
	assign sub_d   = {1'b0, acc_rd} - {1'b0, m_rd} - (LIMB_BITS+1)'(borrow_q);

	// MAC sub-steps per limb j (ph): 0 address, 1 mul xi*yj, 2 mul ui*mj, 3 write
	always_comb begin
		op_raddr  = j_q[AW-1:0];
		acc_raddr = j_q[AAW-1:0];
		acc_we    = 1'b0;
		acc_waddr = j_q[AAW-1:0];
		acc_wdata = '0;
		mul_a     = xi_q;
		mul_b     = y_rd;
		case (state_q)
			ST_CLEAR: begin
				acc_we    = 1'b1;
				acc_waddr = j_q[AAW-1:0];
			end
			ST_U0: begin
				op_raddr  = i_q[AW-1:0];
				acc_raddr = '0;
			end
			ST_U1: begin
				// ph1: xi*y0, ph2: (low product + r0) * m'
				op_raddr = '0;
				mul_a    = (ph_q == 2'd2) ? (prod_s1[LIMB_BITS-1:0] + a0_q) : xi_q;
				mul_b    = (ph_q == 2'd2) ? minv_q : y_rd;
			end
			ST_MAC: begin
				mul_a = (ph_q == 2'd1) ? xi_q : ui_q;
				mul_b = (ph_q == 2'd1) ? y_rd : m_rd;
				if (ph_q == 2'd3 && j_q != '0) begin
					acc_we    = 1'b1;
					acc_waddr = AAW'(j_q - IW'(1));
					acc_wdata = t2_sum[LIMB_BITS-1:0];
				end
			end
			ST_TOP: begin
				acc_raddr = n_q[AAW-1:0];
				if (ph_q == 2'd1) begin
					acc_we    = 1'b1;
					acc_waddr = AAW'(n_q - IW'(1));
					acc_wdata = top_sum[LIMB_BITS-1:0];
				end else if (ph_q == 2'd2) begin
					acc_we    = 1'b1;
					acc_waddr = n_q[AAW-1:0];
					acc_wdata = LIMB_BITS'(top_sum[LIMB_BITS+1:LIMB_BITS]);
				end
			end
			ST_CMP: begin
				// read data is registered and arrives in the cycle after its address
				if (ph_q == 2'd0) begin
					acc_raddr = n_q[AAW-1:0];
				end else if (ph_q == 2'd1) begin
					op_raddr  = j_q[AW-1:0];
					acc_raddr = j_q[AAW-1:0];
				end else begin
					op_raddr  = AW'(j_q - IW'(1));
					acc_raddr = AAW'(j_q - IW'(1));
				end
			end
			ST_SUB: begin
				op_raddr  = j_q[AW-1:0];
				acc_raddr = j_q[AAW-1:0];
				if (ph_q == 2'd1) begin
					acc_we    = 1'b1;
					acc_waddr = j_q[AAW-1:0];
					acc_wdata = sub_d[LIMB_BITS-1:0];
				end
			end
			ST_EMIT: begin
				acc_raddr = j_q[AAW-1:0];
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: if (in_xfer && IW'(load_q) + IW'(1) >= n_eff) state_d = ST_CLEAR;
			ST_CLEAR: if (j_q == n_q) state_d = ST_U0;
			ST_U0: state_d = ST_U1;
			ST_U1: if (ph_q == 2'd3) state_d = ST_MAC;
			ST_MAC: if (ph_q == 2'd3 && j_q + IW'(1) == n_q) state_d = ST_TOP;
			ST_TOP: if (ph_q == 2'd2) state_d = (i_q + IW'(1) == n_q) ? ST_CMP : ST_U0;
			ST_CMP: if (cmp_done_q) state_d = ge_q ? ST_SUB : ST_EMIT;
			ST_SUB: if (ph_q == 2'd1 && j_q + IW'(1) == n_q) state_d = ST_EMIT;
			ST_EMIT: if (out_xfer && out_data.last_out) state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		in_stall = (state_q != ST_LOAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			limb_count_q <= CNT_W'(32);
			minv_q       <= '0;
			load_q       <= '0;
			n_q          <= '0;
			i_q          <= '0;
			j_q          <= '0;
			ph_q         <= '0;
			out_valid    <= 1'b0;
			cmp_done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_LIMB_COUNT: limb_count_q <= cfg_data[CNT_W-1:0];
					REG_MOD_INV:    minv_q       <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (state_d == ST_CLEAR) begin
							load_q <= '0;
							n_q    <= n_eff;
							j_q    <= '0;
							i_q    <= '0;
						end else begin
							load_q <= load_q + CNT_W'(1);
						end
					end
				end
				ST_CLEAR: begin
					j_q  <= (j_q == n_q) ? '0 : j_q + IW'(1);
					ph_q <= '0;
				end
				ST_U0: ph_q <= '0;
				ST_U1: begin
					if (ph_q == 2'd3) begin
						j_q  <= '0;
						ph_q <= '0;
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				ST_MAC: begin
					if (ph_q == 2'd3) begin
						ph_q <= '0;
						j_q  <= j_q + IW'(1);
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				ST_TOP: begin
					if (ph_q == 2'd2) begin
						ph_q       <= '0;
						j_q        <= '0;
						i_q        <= i_q + IW'(1);
						cmp_done_q <= 1'b0;
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				ST_CMP: begin
					if (cmp_done_q) begin
						ph_q       <= '0;
						j_q        <= '0;
						cmp_done_q <= 1'b0;
					end else if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
						j_q  <= n_q - IW'(1);
					end else if (ph_q == 2'd1) begin
						// top limb nonzero means r >= m already
						ph_q <= 2'd2;
						if (acc_rd != '0) cmp_done_q <= 1'b1;
					end else begin
						// scan from top limb down to first difference
						if (acc_rd != m_rd || j_q == '0) begin
							cmp_done_q <= 1'b1;
						end else begin
							j_q <= j_q - IW'(1);
						end
					end
				end
				ST_SUB: begin
					if (ph_q == 2'd1) begin
						ph_q <= '0;
						j_q  <= (state_d == ST_EMIT) ? '0 : j_q + IW'(1);
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				ST_EMIT: begin
					if (!out_valid) begin
						ph_q <= ph_q + 2'd1;
						if (ph_q == 2'd1) out_valid <= 1'b1;
					end else if (out_xfer) begin
						out_valid <= 1'b0;
						ph_q      <= '0;
						j_q       <= out_data.last_out ? '0 : j_q + IW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		case (state_q)
			ST_U0: ;
			ST_U1: begin
				if (ph_q == 2'd0) begin
					xi_q <= x_rd;
					a0_q <= acc_rd;
				end
				if (ph_q == 2'd3) begin
					ui_q <= prod_s1[LIMB_BITS-1:0];
					c1_q <= '0;
					c2_q <= '0;
				end
			end
			ST_MAC: begin
				if (ph_q == 2'd2) begin
					c1_q   <= t1_sum[2*LIMB_BITS-1:LIMB_BITS];
					t1lo_q <= t1_sum[LIMB_BITS-1:0];
				end
				if (ph_q == 2'd3) c2_q <= t2_sum[2*LIMB_BITS-1:LIMB_BITS];
			end
			ST_CMP: begin
				if (!cmp_done_q) begin
					if (ph_q == 2'd0) begin
						borrow_q <= 1'b0;
					end else if (ph_q == 2'd1) begin
						ge_q <= (acc_rd != '0);
					end else begin
						ge_q <= (acc_rd == m_rd) ? 1'b1 : (acc_rd > m_rd);
					end
				end
			end
			ST_SUB: if (ph_q == 2'd1) borrow_q <= sub_d[LIMB_BITS];
			ST_EMIT: if (!out_valid && ph_q == 2'd1) begin
				out_data.result_limb <= acc_rd;
				out_data.last_out    <= (j_q + IW'(1) == n_q);
			end
			default: ;
		endcase
	end
endmodule

>>> rtl/core/mmws_ram.sv
module mmws_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/mmws_checker.sv
module mmws_checker
	import mmws_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last_out |=> in_stall)
		else $error("input reopened before last transfer");
endmodule

bind montgomery_modmul_word_serial mmws_checker u_mmws_checker (
	.clk, .arst_n, .in_stall, .out_valid, .out_stall, .out_data);
